// ----- hw/rtl/meter_pulse_flow_alarm_unit_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef METER_PULSE_FLOW_ALARM_UNIT_ASSERT_SVH
`define METER_PULSE_FLOW_ALARM_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MPFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define MPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/mpfa_pkg.sv -----
package mpfa_pkg;

    // Field widths
    localparam int PULSE_W    = 32;
    localparam int TIME_W     = 32;
    localparam int BATT_W     = 16;
    localparam int LIMIT_W    = 16;
    localparam int BLIM_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int SCALE_W    = 12;
    localparam int PROD_W     = PULSE_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pulses per hour from pulses per second
    localparam logic [SCALE_W-1:0] FLOW_SCALE = SCALE_W'(3600);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    // Alarm bookkeeping
    localparam int ALARM_COUNT       = 6;
    localparam int DEF_REARM_REPEATS = 10;

    localparam int ALM_PEAK_HIGH = 0;
    localparam int ALM_PEAK_LOW  = 1;
    localparam int ALM_FLOW_HIGH = 2;
    localparam int ALM_FLOW_LOW  = 3;
    localparam int ALM_BATT_LOW  = 4;
    localparam int ALM_CUT       = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_DIV  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] RST_FLOW_HIGH = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] RST_FLOW_LOW  = 16'h0000;
    localparam logic [LIMIT_W-1:0] RST_PEAK_HIGH = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] RST_PEAK_LOW  = 16'h0000;
    localparam logic [BLIM_W-1:0]  RST_BATT_LOW  = 8'd10;

    typedef struct packed {
        logic [LIMIT_W-1:0] flow_high;
        logic [LIMIT_W-1:0] flow_low;
        logic [LIMIT_W-1:0] peak_high;
        logic [LIMIT_W-1:0] peak_low;
        logic [BLIM_W-1:0]  battery_low;
    } limits_t;

endpackage

// ----- hw/rtl/mpfa_divider.sv -----
module mpfa_divider
    import mpfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [PROD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]   work_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] div_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                run_reg;
    logic                done_reg;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, work_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    // Control: count the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= CNT_W'(PROD_W);
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out and the quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= {work_reg[PROD_W-2:0], fits};
            rem_reg  <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// ----- hw/rtl/mpfa_alarm.sv -----
module mpfa_alarm
    import mpfa_pkg::*;
#(
    parameter int REARM_REPEATS = DEF_REARM_REPEATS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      update,
    input  logic signed [PULSE_W-1:0] quantity,
    input  logic signed [PULSE_W-1:0] flow,
    input  logic [BATT_W-1:0]         battery_level,
    input  logic                      cut_detect,
    input  limits_t                   limits,
    output logic [ALARM_COUNT-1:0]    flags
);

    localparam int CNT_W = $clog2(REARM_REPEATS + 1);

    logic [ALARM_COUNT-1:0] cond;

    // Threshold conditions; limits are unsigned, quantity and flow signed
    always_comb
    begin
        cond[ALM_PEAK_HIGH] =
            quantity > $signed({{(PULSE_W-LIMIT_W){1'b0}}, limits.peak_high});
        cond[ALM_PEAK_LOW]  =
            quantity < $signed({{(PULSE_W-LIMIT_W){1'b0}}, limits.peak_low});
        cond[ALM_FLOW_HIGH] =
            flow > $signed({{(PULSE_W-LIMIT_W){1'b0}}, limits.flow_high});
        cond[ALM_FLOW_LOW]  =
            flow < $signed({{(PULSE_W-LIMIT_W){1'b0}}, limits.flow_low});
        cond[ALM_BATT_LOW]  =
            battery_level < {{(BATT_W-BLIM_W){1'b0}}, limits.battery_low};
        cond[ALM_CUT]       = cut_detect;
    end

    // Per-flag repeat counter: raise once, then hold off until rearmed
    for (genvar i = 0; i < ALARM_COUNT; i++)
    begin : g_flag
        logic [CNT_W-1:0] cnt_reg;
        logic [CNT_W-1:0] cnt_next;
        logic [CNT_W-1:0] inc;

        assign inc      = cnt_reg + 1'b1;
        assign flags[i] = cond[i] && (cnt_reg == '0);

        always_comb
        begin
            if (!cond[i])
            begin
                cnt_next = '0;
            end
            else if (cnt_reg == '0)
            begin
                cnt_next = CNT_W'(1);
            end
            else if (inc >= CNT_W'(REARM_REPEATS))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = inc;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg <= '0;
            end
            else if (update)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ----- hw/rtl/meter_pulse_flow_alarm_unit.sv -----
// Meter pulse flow alarm unit. Each input transfer is one log sample; exactly one
// result transfer follows. The quantity is the pulse count (divided by four in
// quadrature mode) minus the previous sample's, read as a signed 32-bit value;
// the flow is quantity * 3600 / elapsed seconds, the period saturated at 65535
// and the flow saturated to signed 32 bits. Six alarm flags are raised on the
// first sample of a violation and held off for REARM_REPEATS - 1 repeats. A
// checked sample passes through S_PREP, S_MUL, S_DIV and S_FIX to S_OUT; S_DIV
// waits on the bit-serial restoring divider, one of 44 quotient bits per cycle;
// the first sample after reset and samples with no time advance go to S_OUT.
// A new sample is taken once the previous result sits in the output register,
// while that result still waits for its transfer. Configuration writes are
// taken at any time and must only be issued while the unit is idle.
module meter_pulse_flow_alarm_unit
    import mpfa_pkg::*;
#(
    parameter int REARM_REPEATS = DEF_REARM_REPEATS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // Sample channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PULSE_W-1:0]        pulse_count,
    input  logic [TIME_W-1:0]         time_seconds,
    input  logic [BATT_W-1:0]         battery_level,
    input  logic                      cut_detect,
    // Result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [PULSE_W-1:0] quantity,
    output logic signed [PULSE_W-1:0] flow_per_hour,
    output logic                      checked,
    output logic                      alarm_peak_high,
    output logic                      alarm_peak_low,
    output logic                      alarm_flow_high,
    output logic                      alarm_flow_low,
    output logic                      alarm_battery_low,
    output logic                      alarm_cut,
    output logic                      any_alarm
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;

    limits_t               limits_reg;
    logic                  quad_reg;

    logic                  base_valid_reg;
    logic [PULSE_W-1:0]    last_pulse_reg;
    logic [TIME_W-1:0]     last_time_reg;

    logic                  check_reg;
    logic [PULSE_W-1:0]    q_reg;
    logic [TIME_W-1:0]     diff_reg;
    logic [BATT_W-1:0]     battery_reg;
    logic                  cut_reg;
    logic [PULSE_W-1:0]    mag_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [PULSE_W-1:0]    flow_reg;

    logic                  out_valid_reg;
    logic [PULSE_W-1:0]    quantity_reg;
    logic [PULSE_W-1:0]    flow_out_reg;
    logic                  checked_reg;
    logic [ALARM_COUNT-1:0] flags_reg;
    logic                  any_reg;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  out_load;
    logic [PULSE_W-1:0]    cur;
    logic [TIME_W:0]       time_delta;
    logic                  advance;
    logic [PROD_W-1:0]     product;
    logic                  div_start;
    logic                  div_done;
    logic [PROD_W-1:0]     quotient;
    logic [PULSE_W-1:0]    flow_sat;
    logic                  alarm_update;
    logic [ALARM_COUNT-1:0] flags;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Current count and time advance against the baseline
    assign cur        = quad_reg ? {2'b00, pulse_count[PULSE_W-1:2]} : pulse_count;
    assign time_delta = {1'b0, time_seconds} - {1'b0, last_time_reg};
    assign advance    = !time_delta[TIME_W] && (time_delta[TIME_W-1:0] != '0);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.flow_high   <= RST_FLOW_HIGH;
            limits_reg.flow_low    <= RST_FLOW_LOW;
            limits_reg.peak_high   <= RST_PEAK_HIGH;
            limits_reg.peak_low    <= RST_PEAK_LOW;
            limits_reg.battery_low <= RST_BATT_LOW;
            quad_reg               <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLOW_HIGH: limits_reg.flow_high   <= cfg_data[LIMIT_W-1:0];
                REG_FLOW_LOW:  limits_reg.flow_low    <= cfg_data[LIMIT_W-1:0];
                REG_PEAK_HIGH: limits_reg.peak_high   <= cfg_data[LIMIT_W-1:0];
                REG_PEAK_LOW:  limits_reg.peak_low    <= cfg_data[LIMIT_W-1:0];
                REG_BATT_LOW:  limits_reg.battery_low <= cfg_data[BLIM_W-1:0];
                REG_QUAD_DIV:  quad_reg               <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = (base_valid_reg && advance) ? S_PREP : S_OUT;
            S_PREP:  state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_FIX;
            S_FIX:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Baseline: every sample becomes the new reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_valid_reg <= 1'b0;
            last_pulse_reg <= '0;
            last_time_reg  <= '0;
        end
        else if (in_xfer)
        begin
            base_valid_reg <= 1'b1;
            last_pulse_reg <= cur;
            last_time_reg  <= time_seconds;
        end
    end

    // Capture the sample and its differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            check_reg <= base_valid_reg && advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            q_reg       <= cur - last_pulse_reg;
            diff_reg    <= time_delta[TIME_W-1:0];
            battery_reg <= battery_level;
            cut_reg     <= cut_detect;
        end
    end

    // Magnitude of the quantity and saturated period
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PREP)
        begin
            mag_reg    <= q_reg[PULSE_W-1] ? (~q_reg + 1'b1) : q_reg;
            period_reg <= (diff_reg[TIME_W-1:PERIOD_W] != '0) ? PERIOD_MAX
                                                              : diff_reg[PERIOD_W-1:0];
        end
    end

    // Scale to pulses per hour; the divider registers the product
    assign product   = PROD_W'(mag_reg) * PROD_W'(FLOW_SCALE);
    assign div_start = (state_reg == S_MUL);

    mpfa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Restore the sign and saturate to the signed 32-bit range
    always_comb
    begin
        if (!q_reg[PULSE_W-1])
        begin
            if (quotient[PROD_W-1:PULSE_W-1] != '0)
            begin
                flow_sat = {1'b0, {(PULSE_W-1){1'b1}}};
            end
            else
            begin
                flow_sat = quotient[PULSE_W-1:0];
            end
        end
        else
        begin
            if ((quotient[PROD_W-1:PULSE_W] != '0) ||
                (quotient[PULSE_W-1] && (quotient[PULSE_W-2:0] != '0)))
            begin
                flow_sat = {1'b1, {(PULSE_W-1){1'b0}}};
            end
            else
            begin
                flow_sat = ~quotient[PULSE_W-1:0] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIX)
        begin
            flow_reg <= flow_sat;
        end
    end

    // Alarm evaluation, committed when a checked result is loaded
    assign alarm_update = out_load && check_reg;

    mpfa_alarm #(
        .REARM_REPEATS (REARM_REPEATS)
    ) u_alarm (
        .clk           (clk),
        .rst_n         (rst_n),
        .update        (alarm_update),
        .quantity      ($signed(q_reg)),
        .flow          ($signed(flow_reg)),
        .battery_level (battery_reg),
        .cut_detect    (cut_reg),
        .limits        (limits_reg),
        .flags         (flags)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (check_reg)
            begin
                quantity_reg <= q_reg;
                flow_out_reg <= flow_reg;
                checked_reg  <= 1'b1;
                flags_reg    <= flags;
                any_reg      <= |flags;
            end
            else
            begin
                quantity_reg <= '0;
                flow_out_reg <= '0;
                checked_reg  <= 1'b0;
                flags_reg    <= '0;
                any_reg      <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign quantity          = $signed(quantity_reg);
    assign flow_per_hour     = $signed(flow_out_reg);
    assign checked           = checked_reg;
    assign alarm_peak_high   = flags_reg[ALM_PEAK_HIGH];
    assign alarm_peak_low    = flags_reg[ALM_PEAK_LOW];
    assign alarm_flow_high   = flags_reg[ALM_FLOW_HIGH];
    assign alarm_flow_low    = flags_reg[ALM_FLOW_LOW];
    assign alarm_battery_low = flags_reg[ALM_BATT_LOW];
    assign alarm_cut         = flags_reg[ALM_CUT];
    assign any_alarm         = any_reg;

endmodule

// ----- hw/rtl/mpfa_checker.sv -----
`include "meter_pulse_flow_alarm_unit_assert.svh"

module mpfa_checker
    import mpfa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [PULSE_W-1:0] quantity,
    input logic signed [PULSE_W-1:0] flow_per_hour,
    input logic                      checked,
    input logic                      alarm_peak_high,
    input logic                      alarm_peak_low,
    input logic                      alarm_flow_high,
    input logic                      alarm_flow_low,
    input logic                      alarm_battery_low,
    input logic                      alarm_cut,
    input logic                      any_alarm
);

    logic               flag_or;
    logic               result_zero;
    logic [2*PULSE_W:0] result_word;

    // Summarize the result fields for the checks below
    assign flag_or     = alarm_peak_high || alarm_peak_low || alarm_flow_high ||
                         alarm_flow_low || alarm_battery_low || alarm_cut;
    assign result_zero = (quantity == '0) && (flow_per_hour == '0) && !any_alarm;
    assign result_word = {quantity, flow_per_hour, checked};

    // One sample at a time: a transfer closes the input until its result is built
    `MPFA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // The summary flag is the OR of the six flags
    `MPFA_ASSERT_NOW(a_any_is_or, clk, rst_n, out_valid, any_alarm == flag_or)

    // An unchecked sample reports nothing
    `MPFA_ASSERT_NOW(a_unchecked_zero, clk, rst_n, out_valid && !checked, result_zero)

    // A stalled result holds
    `MPFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_word))

endmodule

bind meter_pulse_flow_alarm_unit mpfa_checker u_checker (.*);

// ----- tb/meter_flow_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the register port of the meter flow alarm unit.
// It mirrors the limits and the sample history, predicts the result of each
// accepted sample and compares every result transfer with the oldest prediction.
module meter_flow_checker
    import mpfa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [PULSE_W-1:0]        pulse_count,
    input  logic [TIME_W-1:0]         time_seconds,
    input  logic [BATT_W-1:0]         battery_level,
    input  logic                      cut_detect,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [PULSE_W-1:0] quantity,
    input  logic signed [PULSE_W-1:0] flow_per_hour,
    input  logic                      checked,
    input  logic                      alarm_peak_high,
    input  logic                      alarm_peak_low,
    input  logic                      alarm_flow_high,
    input  logic                      alarm_flow_low,
    input  logic                      alarm_battery_low,
    input  logic                      alarm_cut,
    input  logic                      any_alarm,
    output int                        fail_count,
    output int                        pending_results
);

    localparam longint SECS_PER_HOUR = 3600;
    localparam longint FLOW_MAX      = 64'sd2147483647;
    localparam longint FLOW_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic [PULSE_W-1:0]     qty;
        logic [PULSE_W-1:0]     flow;
        logic                   chk;
        logic [ALARM_COUNT-1:0] alarms;
        logic                   any;
    } meter_result_t;

    // Mirrored limits
    longint            lim_flow_high;
    longint            lim_flow_low;
    longint            lim_peak_high;
    longint            lim_peak_low;
    logic [BLIM_W-1:0] lim_batt;
    logic              quad_div;

    // Mirrored sample history
    logic               have_base;
    logic [PULSE_W-1:0] base_pulse;
    logic [TIME_W-1:0]  base_time;
    logic [7:0]         repeat_cnt [ALARM_COUNT];

    meter_result_t result_q [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
        end
    endtask

    // Raise on the first sample of a violation, then hold off until the counter rearms
    function automatic logic alarm_edge(input int idx, input logic cond);
        logic raised;
        raised = 1'b0;
        if (!cond)
        begin
            repeat_cnt[idx] = '0;
        end
        else if (repeat_cnt[idx] == '0)
        begin
            repeat_cnt[idx] = 8'd1;
            raised = 1'b1;
        end
        else if (int'(repeat_cnt[idx]) + 1 >= DEF_REARM_REPEATS)
        begin
            repeat_cnt[idx] = '0;
        end
        else
        begin
            repeat_cnt[idx] = repeat_cnt[idx] + 8'd1;
        end
        return raised;
    endfunction

    task automatic predict_sample(input logic [PULSE_W-1:0] pulse, input logic [TIME_W-1:0] now,
                                  input logic [BATT_W-1:0] batt, input logic cut,
                                  output meter_result_t res);
        logic [PULSE_W-1:0]        cur;
        logic [TIME_W-1:0]         span;
        logic signed [PULSE_W-1:0] qs;
        longint                    q64;
        longint                    per64;
        longint                    flow64;
        logic [ALARM_COUNT-1:0]    hit;
        res = '0;
        cur = quad_div ? (pulse >> 2) : pulse;
        if (have_base && now > base_time)
        begin
            // Period in seconds, clipped to 16 bits
            span  = now - base_time;
            per64 = span;
            if (per64 > PERIOD_MAX)
            begin
                per64 = PERIOD_MAX;
            end
            // Quantity is the modular difference read as signed
            qs     = cur - base_pulse;
            q64    = qs;
            flow64 = (q64 * SECS_PER_HOUR) / per64;
            if (flow64 > FLOW_MAX)
            begin
                flow64 = FLOW_MAX;
            end
            if (flow64 < FLOW_MIN)
            begin
                flow64 = FLOW_MIN;
            end
            hit[ALM_PEAK_HIGH] = alarm_edge(ALM_PEAK_HIGH, q64 > lim_peak_high);
            hit[ALM_PEAK_LOW]  = alarm_edge(ALM_PEAK_LOW, q64 < lim_peak_low);
            hit[ALM_FLOW_HIGH] = alarm_edge(ALM_FLOW_HIGH, flow64 > lim_flow_high);
            hit[ALM_FLOW_LOW]  = alarm_edge(ALM_FLOW_LOW, flow64 < lim_flow_low);
            hit[ALM_BATT_LOW]  = alarm_edge(ALM_BATT_LOW, batt < lim_batt);
            hit[ALM_CUT]       = alarm_edge(ALM_CUT, cut);
            res.qty    = qs;
            res.flow   = flow64[PULSE_W-1:0];
            res.chk    = 1'b1;
            res.alarms = hit;
            res.any    = |hit;
        end
        // Every sample becomes the new baseline
        base_pulse = cur;
        base_time  = now;
        have_base  = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        meter_result_t want;
        meter_result_t due;
        if (!rst_n)
        begin
            lim_flow_high = RST_FLOW_HIGH;
            lim_flow_low  = RST_FLOW_LOW;
            lim_peak_high = RST_PEAK_HIGH;
            lim_peak_low  = RST_PEAK_LOW;
            lim_batt      = RST_BATT_LOW;
            quad_div      = 1'b0;
            have_base     = 1'b0;
            base_pulse    = '0;
            base_time     = '0;
            for (int i = 0; i < ALARM_COUNT; i++)
            begin
                repeat_cnt[i] = '0;
            end
            result_q.delete();
            pending_results <= 0;
        end
        else
        begin
            // Mirror register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FLOW_HIGH: lim_flow_high = cfg_data;
                    REG_FLOW_LOW:  lim_flow_low  = cfg_data;
                    REG_PEAK_HIGH: lim_peak_high = cfg_data;
                    REG_PEAK_LOW:  lim_peak_low  = cfg_data;
                    REG_BATT_LOW:  lim_batt      = cfg_data[BLIM_W-1:0];
                    REG_QUAD_DIV:  quad_div      = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare a result transfer with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("result transfer with no sample waiting");
                end
                else
                begin
                    due = result_q.pop_front();
                    check_field("quantity", due.qty, quantity);
                    check_field("flow_per_hour", due.flow, flow_per_hour);
                    check_field("checked", due.chk, checked);
                    check_field("alarm_peak_high", due.alarms[ALM_PEAK_HIGH], alarm_peak_high);
                    check_field("alarm_peak_low", due.alarms[ALM_PEAK_LOW], alarm_peak_low);
                    check_field("alarm_flow_high", due.alarms[ALM_FLOW_HIGH], alarm_flow_high);
                    check_field("alarm_flow_low", due.alarms[ALM_FLOW_LOW], alarm_flow_low);
                    check_field("alarm_battery_low", due.alarms[ALM_BATT_LOW],
                                alarm_battery_low);
                    check_field("alarm_cut", due.alarms[ALM_CUT], alarm_cut);
                    check_field("any_alarm", due.any, any_alarm);
                end
            end
            // Predict the result of a sample transfer
            if (in_valid && !in_stall)
            begin
                predict_sample(pulse_count, time_seconds, battery_level, cut_detect, want);
                result_q.push_back(want);
            end
            pending_results <= result_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mpfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int IDLE_PCT       = 19;
    localparam int SEGMENT_COUNT  = 4;
    localparam int SEGMENT_ITEMS  = 95;
    localparam int SETTLE_CYCLES  = 60;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [PULSE_W-1:0]        pulse_count   = '0;
    logic [TIME_W-1:0]         time_seconds  = '0;
    logic [BATT_W-1:0]         battery_level = '0;
    logic                      cut_detect    = 1'b0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic signed [PULSE_W-1:0] quantity;
    logic signed [PULSE_W-1:0] flow_per_hour;
    logic                      checked;
    logic                      alarm_peak_high;
    logic                      alarm_peak_low;
    logic                      alarm_flow_high;
    logic                      alarm_flow_low;
    logic                      alarm_battery_low;
    logic                      alarm_cut;
    logic                      any_alarm;

    logic idle_on      = 1'b1;
    int   results_seen = 0;
    int   fail_count;
    int   pending_results;

    meter_pulse_flow_alarm_unit u_top (.*);

    meter_flow_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count result transfers so the receiver knows when to hold off
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off while samples keep coming
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER && in_valid)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Abort when neither channel moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("meter_pulse_flow_alarm_unit test failed");
        $finish;
    end

    // Offer one sample and hold it until the transfer
    task automatic send_sample(input logic [PULSE_W-1:0] pulse, input logic [TIME_W-1:0] secs,
                               input logic [BATT_W-1:0] batt, input logic cut);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pulse_count   <= pulse;
        time_seconds  <= secs;
        battery_level <= batt;
        cut_detect    <= cut;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram all limits once the unit is idle; unused upper bits carry noise
    task automatic load_limits(input logic [LIMIT_W-1:0] flow_hi, input logic [LIMIT_W-1:0] flow_lo,
                               input logic [LIMIT_W-1:0] peak_hi, input logic [LIMIT_W-1:0] peak_lo,
                               input logic [BLIM_W-1:0] batt_lo, input logic quad);
        wait_drained();
        write_reg(REG_FLOW_HIGH, flow_hi);
        write_reg(REG_FLOW_LOW, flow_lo);
        write_reg(REG_PEAK_HIGH, peak_hi);
        write_reg(REG_PEAK_LOW, peak_lo);
        write_reg(REG_BATT_LOW, {8'($urandom), batt_lo});
        write_reg(REG_QUAD_DIV, {15'($urandom), quad});
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                 pick;
        int                 rate;
        int                 batt_lvl;
        logic [PULSE_W-1:0] gen_pulse;
        logic [TIME_W-1:0]  gen_time;
        logic               cut_lvl;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: first sample, stalled or reversed clock, wrap and reverse rules
        send_sample(32'hFFFF_FFFF, 32'd100, 16'hFFFF, 1'b1);
        send_sample(32'hFFFF_FFFF, 32'd100, 16'h0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 32'd99, 16'h0000, 1'b0);
        send_sample(32'h0000_0009, 32'd100, 16'h0000, 1'b1);
        send_sample(32'hFFFF_FFB9, 32'd101, 16'd9, 1'b1);
        send_sample(32'hFFFF_FF68, 32'd102, 16'd10, 1'b0);
        send_sample(32'hFFFF_FF17, 32'd103, 16'd10, 1'b0);
        // Half-range steps saturate the flow both ways
        send_sample(32'h7FFF_FF17, 32'd104, 16'd11, 1'b0);
        send_sample(32'hFFFF_FF16, 32'd105, 16'd11, 1'b0);
        // Period clipping, time wrap and the quantity limit edge
        send_sample(32'h0000_02FE, 32'h0001_0069, 16'd100, 1'b1);
        send_sample(32'h0000_02FE, 32'hFFFF_FFFF, 16'd100, 1'b1);
        send_sample(32'h0000_02FE, 32'h0000_0000, 16'd100, 1'b1);
        send_sample(32'h0001_02FD, 32'd1, 16'd100, 1'b1);
        send_sample(32'h0002_02FD, 32'd2, 16'd100, 1'b1);
        send_sample(32'h0002_02FD, 32'd3, 16'hFFFF, 1'b0);

        // All limits at zero with quadrature divide
        load_limits('0, '0, '0, '0, '0, 1'b1);
        send_sample(32'h0000_0003, 32'd10, 16'h0000, 1'b0);
        send_sample(32'h0000_03FF, 32'd11, 16'h0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 32'd12, 16'h0000, 1'b1);

        // All limits at their maximum
        load_limits('1, '1, '1, '1, '1, 1'b0);
        send_sample(32'd100, 32'd20, 16'd254, 1'b0);
        send_sample(32'd200, 32'd21, 16'd255, 1'b0);
        send_sample(32'd150, 32'd23, 16'd0, 1'b1);

        // Random phases: mostly steady meter traffic, some noise and stalled clocks
        gen_pulse = $urandom;
        gen_time  = $urandom;
        rate      = 100;
        batt_lvl  = 20;
        cut_lvl   = 1'b0;
        for (int seg = 0; seg < SEGMENT_COUNT; seg++)
        begin
            idle_on <= (seg != 1);
            load_limits(16'($urandom), 16'($urandom_range(20000)), 16'($urandom_range(6000)),
                        16'($urandom_range(400)), 8'($urandom_range(5, 40)), seg == 2);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    send_sample($urandom, $urandom, 16'($urandom), 1'($urandom));
                end
                else if (pick < 17)
                begin
                    send_sample(gen_pulse + $urandom_range(300), gen_time - $urandom_range(3),
                                16'(batt_lvl), cut_lvl);
                end
                else
                begin
                    // Occasionally switch to a new flow regime
                    if ($urandom_range(9) == 0)
                    begin
                        case ($urandom_range(9))
                            6: rate = -int'($urandom_range('h50));
                            7: rate = $urandom_range(3000, 70000);
                            8: rate = 0;
                            9: rate = $urandom;
                            default: rate = $urandom_range(3000);
                        endcase
                    end
                    gen_pulse = gen_pulse + rate + $urandom_range(3);
                    if ($urandom_range(99) < 3)
                    begin
                        gen_time = gen_time + $urandom_range(65536, 300000);
                    end
                    else
                    begin
                        gen_time = gen_time + $urandom_range(1, 900);
                    end
                    // Battery drifts slowly; the cut pin stays put for runs
                    batt_lvl = batt_lvl + int'($urandom_range(4)) - 2;
                    if (batt_lvl < 0)
                    begin
                        batt_lvl = 0;
                    end
                    if (batt_lvl > 60)
                    begin
                        batt_lvl = 60;
                    end
                    if ($urandom_range(99) < 8)
                    begin
                        cut_lvl = !cut_lvl;
                    end
                    send_sample(gen_pulse, gen_time, 16'(batt_lvl), cut_lvl);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("meter_pulse_flow_alarm_unit test passed");
        end
        else
        begin
            $display("meter_pulse_flow_alarm_unit test failed");
        end
        $finish;
    end

endmodule
